// ===== src/brcl_pkg.sv =====
// ----------------------------------------------------------------------------
// brcl_pkg: shared types and constants for the byte ring with commit lock
// Operation codes, sequencer states and the structs passed between modules.
// ----------------------------------------------------------------------------
package brcl_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int SIZE_RESET    = 256;

    typedef enum logic [3:0] {
        OP_WRITE   = 4'd0,
        OP_READ    = 4'd1,
        OP_PEEK    = 4'd2,
        OP_DELETE  = 4'd3,
        OP_UPDATE  = 4'd4,
        OP_LOCK    = 4'd5,
        OP_UNLOCK  = 4'd6,
        OP_DISCARD = 4'd7,
        OP_CLEAR   = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] data_in;
        logic [7:0] offset;
        logic [8:0] drop_count;
    } item_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    typedef struct packed {
        logic       ok;
        logic       rd_sel;
        logic [7:0] written_count;
        logic [7:0] readable_count;
        logic       locked;
        logic       empty;
    } meta_t;

endpackage

// ===== src/brcl_ram.sv =====
// ----------------------------------------------------------------------------
// brcl_ram: byte store
// Single-port synchronous RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module brcl_ram
    import brcl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  mem_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/brcl_ptr.sv =====
// ----------------------------------------------------------------------------
// brcl_ptr: ring pointers and operation decode
// Holds read, write and lock positions and the ring size; works out the
// memory access and the next positions for one operation.
// ----------------------------------------------------------------------------
module brcl_ptr
    import brcl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [8:0]               cfg_size,
    input  logic                     exec,
    input  item_t                    item,
    output mem_ctl_t                 mem_ctl,
    output logic [$clog2(DEPTH)-1:0] mem_addr,
    output logic [7:0]               mem_wdata,
    output meta_t                    meta
);

    localparam int PW        = $clog2(DEPTH);
    localparam int SW        = $clog2(DEPTH + 1);
    localparam int CW        = (SW > 9) ? SW : 9;
    localparam int AW        = CW + 1;
    localparam int SIZE_INIT = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] lp_reg, lp_next;
    logic          la_reg, la_next;
    logic [SW-1:0] size_reg;
    logic [AW-1:0] size_ext;
    logic [AW-1:0] cfg_clamped;

    function automatic logic [PW-1:0] ring_add(logic [PW-1:0] base, logic [AW-1:0] off,
                                               logic [AW-1:0] sz);
        logic [AW-1:0] s;
        s = AW'(base) + off;
        if (s >= sz)
        begin
            s = s - sz;
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_dist(logic [PW-1:0] from, logic [PW-1:0] to,
                                                logic [AW-1:0] sz);
        if (to >= from)
        begin
            return AW'(to) - AW'(from);
        end
        return AW'(to) + sz - AW'(from);
    endfunction

    assign size_ext = AW'(size_reg);

    always_comb
    begin
        cfg_clamped = AW'(cfg_size);
        if (cfg_clamped < AW'(2))
        begin
            cfg_clamped = AW'(2);
        end
        if (cfg_clamped > AW'(DEPTH))
        begin
            cfg_clamped = AW'(DEPTH);
        end
    end

    always_comb
    begin
        logic          empty;
        logic [AW-1:0] held;
        logic [AW-1:0] rdbl;
        logic [PW-1:0] limit;
        logic [PW-1:0] lim_n;
        logic [AW-1:0] held_n;
        logic [AW-1:0] rdbl_n;

        empty     = (rp_reg == wp_reg);
        held      = ring_dist(rp_reg, wp_reg, size_ext);
        limit     = la_reg ? lp_reg : wp_reg;
        rdbl      = ring_dist(rp_reg, limit, size_ext);
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        lp_next   = lp_reg;
        la_next   = la_reg;
        mem_ctl   = '0;
        mem_addr  = rp_reg;
        mem_wdata = item.data_in;
        meta      = '0;

        unique case (item.op)
            OP_WRITE:
            begin
                mem_ctl.we = 1'b1;
                mem_addr   = wp_reg;
                wp_next    = ring_add(wp_reg, AW'(1), size_ext);
                if (wp_next == rp_reg)
                begin
                    rp_next = ring_add(rp_reg, AW'(1), size_ext);
                    if (la_reg && lp_reg == rp_next)
                    begin
                        lp_next = ring_add(lp_reg, AW'(1), size_ext);
                    end
                end
                meta.ok = 1'b1;
            end
            OP_READ:
            begin
                if (!empty && rdbl != '0)
                begin
                    mem_ctl.re  = 1'b1;
                    rp_next     = ring_add(rp_reg, AW'(1), size_ext);
                    meta.ok     = 1'b1;
                    meta.rd_sel = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (!empty && AW'(item.offset) < held)
                begin
                    mem_ctl.re  = 1'b1;
                    mem_addr    = ring_add(rp_reg, AW'(item.offset), size_ext);
                    meta.ok     = 1'b1;
                    meta.rd_sel = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (!empty && AW'(item.drop_count) <= rdbl)
                begin
                    rp_next = ring_add(rp_reg, AW'(item.drop_count), size_ext);
                    meta.ok = 1'b1;
                end
            end
            OP_UPDATE:
            begin
                if (!empty && AW'(item.offset) < rdbl)
                begin
                    mem_ctl.we = 1'b1;
                    mem_addr   = ring_add(rp_reg, AW'(item.offset), size_ext);
                    meta.ok    = 1'b1;
                end
            end
            OP_LOCK:
            begin
                lp_next = wp_reg;
                la_next = 1'b1;
                meta.ok = 1'b1;
            end
            OP_UNLOCK:
            begin
                la_next = 1'b0;
                meta.ok = 1'b1;
            end
            OP_DISCARD:
            begin
                if (la_reg)
                begin
                    wp_next = lp_reg;
                end
                la_next = 1'b0;
                meta.ok = 1'b1;
            end
            OP_CLEAR:
            begin
                rp_next = '0;
                wp_next = '0;
                lp_next = '0;
                la_next = 1'b0;
                meta.ok = 1'b1;
            end
            default:
            begin
            end
        endcase

        // RAM is only touched in the execute cycle
        if (!exec)
        begin
            mem_ctl = '0;
        end

        lim_n               = la_next ? lp_next : wp_next;
        held_n              = ring_dist(rp_next, wp_next, size_ext);
        rdbl_n              = ring_dist(rp_next, lim_n, size_ext);
        meta.written_count  = held_n[7:0];
        meta.readable_count = rdbl_n[7:0];
        meta.locked         = la_next;
        meta.empty          = (rp_next == wp_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            lp_reg   <= '0;
            la_reg   <= 1'b0;
            size_reg <= SW'(SIZE_INIT);
        end
        else if (cfg_wr_en)
        begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            lp_reg   <= '0;
            la_reg   <= 1'b0;
            size_reg <= cfg_clamped[SW-1:0];
        end
        else if (exec)
        begin
            rp_reg <= rp_next;
            wp_reg <= wp_next;
            lp_reg <= lp_next;
            la_reg <= la_next;
        end
    end

endmodule

// ===== src/byte_ring_with_commit_lock_unit.sv =====
// ----------------------------------------------------------------------------
// byte_ring_with_commit_lock_unit: overwriting byte ring with commit lock
// Byte ring of size_in_use slots with lock, commit and rollback operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat: op,
//   data_in, offset, drop_count. Output channel (out_valid / out_stall)
//   returns one result beat per operation: ok, data_out, written_count,
//   readable_count, is_locked, is_empty.
//   cfg_wr_en with size_in_use sets the ring size and empties the ring;
//   write it only while no operation is outstanding.
//   An accepted operation is registered, executed on the pointers and RAM,
//   and its result then moves into the output register. The single RAM port
//   is used in the execute cycle and its registered read data in the next one.
//   Only one operation is in flight; the next is taken in the cycle its
//   predecessor's result moves into the output register.
//   Receiver stall: the result beat is held, and once the pending result is
//   also blocked the input is stalled.
//   Reset: ring empty, unlocked, size 256 (capped at DEPTH). RAM contents are
//   not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_ring_with_commit_lock_unit
    import brcl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [8:0] size_in_use,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] op,
    input  logic [7:0] data_in,
    input  logic [7:0] offset,
    input  logic [8:0] drop_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ok,
    output logic [7:0] data_out,
    output logic [7:0] written_count,
    output logic [7:0] readable_count,
    output logic       is_locked,
    output logic       is_empty
);

    localparam int PW = $clog2(DEPTH);

    state_t        state_reg, state_next;
    item_t         item_reg;
    meta_t         pend_reg;
    meta_t         meta;
    mem_ctl_t      mem_ctl;
    logic [PW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic          accept;
    logic          load_out;
    logic          out_free;
    logic          exec;
    logic          out_valid_reg;
    meta_t         out_meta_reg;
    logic [7:0]    out_data_reg;

    brcl_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_size  (size_in_use),
        .exec      (exec),
        .item      (item_reg),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .meta      (meta)
    );

    brcl_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        exec     = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_EXEC:
            begin
                exec = 1'b1;
            end
            ST_DONE:
            begin
                in_stall = !out_free;
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
        accept = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{op: op, data_in: data_in, offset: offset, drop_count: drop_count};
        end
        if (exec)
        begin
            pend_reg <= meta;
        end
        if (load_out)
        begin
            out_meta_reg <= pend_reg;
            out_data_reg <= pend_reg.rd_sel ? mem_rdata : 8'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = out_meta_reg.ok;
    assign data_out       = out_data_reg;
    assign written_count  = out_meta_reg.written_count;
    assign readable_count = out_meta_reg.readable_count;
    assign is_locked      = out_meta_reg.locked;
    assign is_empty       = out_meta_reg.empty;

endmodule

// ===== src/brcl_checker.sv =====
// ----------------------------------------------------------------------------
// brcl_checker: port-level checks for the byte ring with commit lock
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module brcl_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       ok,
    input logic [7:0] data_out,
    input logic [7:0] written_count,
    input logic [7:0] readable_count,
    input logic       is_locked,
    input logic       is_empty
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(ok)
            && $stable(written_count) && $stable(readable_count))
        else $error("result beat changed while stalled");

    // one operation in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> data_out == 8'd0)
        else $error("data on a failed operation");

    a_unlocked_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_locked |-> readable_count == written_count)
        else $error("readable count differs from held count while unlocked");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> written_count == 8'd0)
        else $error("empty ring reports bytes held");

endmodule

bind byte_ring_with_commit_lock_unit brcl_checker u_brcl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ok             (ok),
    .data_out       (data_out),
    .written_count  (written_count),
    .readable_count (readable_count),
    .is_locked      (is_locked),
    .is_empty       (is_empty)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for byte_ring_with_commit_lock_unit
// Runs directed edge cases, then random operation mixes across several ring
// sizes. The bench predicts each result beat from its own model of the ring.
// Both channels idle and stall at random. Mismatches are each reported and
// counted, and the run prints a summary at the end.
// ----------------------------------------------------------------------------
module testbench;
    import brcl_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 3;
    localparam int MAX_WAIT     = 6;
    localparam int SETTLE       = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int MIN_SLOTS    = 2;
    localparam int OP_CODE_MAX  = 15;
    localparam int PHASES       = 10;

    typedef struct packed {
        logic       ok;
        logic [7:0] data_out;
        logic [7:0] written_count;
        logic [7:0] readable_count;
        logic       is_locked;
        logic       is_empty;
    } ring_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [8:0] size_cfg  = 9'(SIZE_RESET);
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    item_t      presented = '0;
    logic       in_stall;
    logic       out_valid;
    logic       ok;
    logic [7:0] data_out;
    logic [7:0] written_count;
    logic [7:0] readable_count;
    logic       is_locked;
    logic       is_empty;

    item_t        op_backlog[$];
    ring_result_t result_due[$];
    ring_result_t want;

    logic [7:0]  ring_mem [DEPTH_DEFAULT];
    int unsigned rd_idx, wr_idx, mark_idx, slots;
    bit          mark_on;

    int  hold_cycles, stall_left, idle_cycles;
    bit  calm_tx, calm_rx;
    int  failures, ops_sent, beats_checked, sizes_tried;
    int  overwrites, mark_shifts, rollbacks;

    logic [8:0] size_plan [PHASES] = '{9'd2, 9'd5, 9'd0, 9'd17, 9'd511,
                                       9'd3, 9'd1, 9'd256, 9'd9, 9'd64};

    always #(CLK_PERIOD / 2) clk = ~clk;

    byte_ring_with_commit_lock_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .size_in_use    (size_cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (presented.op),
        .data_in        (presented.data_in),
        .offset         (presented.offset),
        .drop_count     (presented.drop_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .data_out       (data_out),
        .written_count  (written_count),
        .readable_count (readable_count),
        .is_locked      (is_locked),
        .is_empty       (is_empty)
    );

    // ---- ring model ----
    function automatic int unsigned next_slot(int unsigned p);
        return (p + 1 >= slots) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_span(int unsigned from, int unsigned to);
        return (to >= from) ? to - from : to + slots - from;
    endfunction

    function automatic int unsigned wrap_add(int unsigned base, int unsigned off);
        int unsigned s;
        s = base + off;
        if (s >= slots)
            s -= slots;
        return s;
    endfunction

    function automatic int unsigned held_span();
        return ring_span(rd_idx, wr_idx);
    endfunction

    function automatic int unsigned ready_span();
        return ring_span(rd_idx, mark_on ? mark_idx : wr_idx);
    endfunction

    function automatic void pop_head();
        if (rd_idx != (mark_on ? mark_idx : wr_idx))
            rd_idx = next_slot(rd_idx);
    endfunction

    function automatic void reset_positions();
        rd_idx   = 0;
        wr_idx   = 0;
        mark_idx = 0;
        mark_on  = 1'b0;
    endfunction

    function automatic ring_result_t ring_outcome(item_t it);
        ring_result_t r;
        bit           was_empty;
        int unsigned  k;
        r = '0;
        was_empty = (rd_idx == wr_idx);
        case (it.op)
            OP_WRITE:
            begin
                ring_mem[wr_idx] = it.data_in;
                wr_idx = next_slot(wr_idx);
                if (wr_idx == rd_idx)
                begin
                    rd_idx = next_slot(rd_idx);
                    overwrites++;
                    if (mark_on && mark_idx == rd_idx)
                    begin
                        mark_idx = next_slot(mark_idx);
                        mark_shifts++;
                    end
                end
                r.ok = 1'b1;
            end
            OP_READ:
                if (!was_empty && ready_span() != 0)
                begin
                    r.data_out = ring_mem[rd_idx];
                    pop_head();
                    r.ok = 1'b1;
                end
            OP_PEEK:
                if (!was_empty && it.offset < held_span())
                begin
                    r.data_out = ring_mem[wrap_add(rd_idx, it.offset)];
                    r.ok = 1'b1;
                end
            OP_DELETE:
                if (!was_empty && it.drop_count <= ready_span())
                begin
                    for (k = 0; k < it.drop_count; k++)
                        pop_head();
                    r.ok = 1'b1;
                end
            OP_UPDATE:
                if (!was_empty && it.offset < ready_span())
                begin
                    ring_mem[wrap_add(rd_idx, it.offset)] = it.data_in;
                    r.ok = 1'b1;
                end
            OP_LOCK:
            begin
                mark_idx = wr_idx;
                mark_on  = 1'b1;
                r.ok     = 1'b1;
            end
            OP_UNLOCK:
            begin
                mark_on = 1'b0;
                r.ok    = 1'b1;
            end
            OP_DISCARD:
            begin
                if (mark_on)
                begin
                    wr_idx = mark_idx;
                    rollbacks++;
                end
                mark_on = 1'b0;
                r.ok    = 1'b1;
            end
            OP_CLEAR:
            begin
                reset_positions();
                r.ok = 1'b1;
            end
            default:
                r.ok = 1'b0;
        endcase
        r.written_count  = 8'(held_span());
        r.readable_count = 8'(ready_span());
        r.is_locked      = mark_on;
        r.is_empty       = (rd_idx == wr_idx);
        return r;
    endfunction

    // ---- stimulus helpers ----
    function automatic void add_op(logic [3:0] code, int unsigned d, int unsigned o,
                                   int unsigned n);
        item_t it;
        it.op         = code;
        it.data_in    = 8'(d);
        it.offset     = 8'(o);
        it.drop_count = 9'(n);
        op_backlog.push_back(it);
    endfunction

    function automatic int unsigned pick_offset(int unsigned s);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, (s > 12) ? 12 : s);
    endfunction

    function automatic void add_random_op(int unsigned s);
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            add_op(OP_WRITE, $urandom_range(0, 255), 0, 0);
        else if (pick < 46)
            add_op(OP_READ, $urandom_range(0, 255), 0, 0);
        else if (pick < 56)
            add_op(OP_PEEK, 0, pick_offset(s), 0);
        else if (pick < 64)
        begin
            case ($urandom_range(0, 9))
                0, 1:    n = $urandom_range(0, 511);
                2, 3, 4: n = $urandom_range(0, s);
                default: n = $urandom_range(0, 3);
            endcase
            add_op(OP_DELETE, 0, 0, n);
        end
        else if (pick < 72)
            add_op(OP_UPDATE, $urandom_range(0, 255), pick_offset(s), 0);
        else if (pick < 78)
            add_op(OP_LOCK, 0, 0, 0);
        else if (pick < 84)
            add_op(OP_UNLOCK, 0, 0, 0);
        else if (pick < 90)
            add_op(OP_DISCARD, 0, 0, 0);
        else if (pick < 93)
            add_op(OP_CLEAR, 0, 0, 0);
        else
            add_op(4'($urandom_range(OP_CLEAR + 1, OP_CODE_MAX)), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 511));
    endfunction

    function automatic void queue_phase(int unsigned s, int unsigned n);
        int unsigned reps, k;
        while (op_backlog.size() < n)
        begin
            case ($urandom_range(0, 24))
                0, 1, 2:
                begin
                    add_op(OP_LOCK, 0, 0, 0);
                    reps = $urandom_range(0, (s < 12) ? s + 2 : 12);
                    for (k = 0; k < reps; k++)
                    begin
                        add_op(OP_WRITE, $urandom_range(0, 255), 0, 0);
                        if ($urandom_range(0, 2) == 0)
                            add_random_op(s);
                    end
                    case ($urandom_range(0, 3))
                        0:       add_op(OP_UNLOCK, 0, 0, 0);
                        1:       add_op(OP_DISCARD, 0, 0, 0);
                        2:       add_op(OP_LOCK, 0, 0, 0);
                        default: ;
                    endcase
                end
                3:
                    if (s <= 20)
                    begin
                        reps = $urandom_range(s - 1, s + 2);
                        for (k = 0; k < reps; k++)
                            add_op(OP_WRITE, $urandom_range(0, 255), 0, 0);
                    end
                default:
                    add_random_op(s);
            endcase
        end
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (op_backlog.size() != 0 || in_valid || result_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_ring_size(logic [8:0] raw);
        int unsigned eff;
        eff = (raw < MIN_SLOTS) ? MIN_SLOTS : ((raw > DEPTH_DEFAULT) ? DEPTH_DEFAULT : raw);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        size_cfg  <= raw;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        slots = eff;
        reset_positions();
        sizes_tried++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            failures++;
        end
    endtask

    // ---- sender ----
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            presented   <= '0;
            hold_cycles = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                result_due.push_back(ring_outcome(presented));
                ops_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (hold_cycles != 0)
                begin
                    hold_cycles--;
                    in_valid <= 1'b0;
                end
                else if (op_backlog.size() != 0)
                begin
                    presented <= op_backlog.pop_front();
                    in_valid  <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        calm_tx = ~calm_tx;
                    hold_cycles = calm_tx ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---- receiver and checker ----
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_due.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    failures++;
                end
                else
                begin
                    want = result_due.pop_front();
                    check_field("ok", want.ok, ok);
                    check_field("data_out", want.data_out, data_out);
                    check_field("written_count", want.written_count, written_count);
                    check_field("readable_count", want.readable_count, readable_count);
                    check_field("is_locked", want.is_locked, is_locked);
                    check_field("is_empty", want.is_empty, is_empty);
                    beats_checked++;
                end
                if ($urandom_range(0, 39) == 0)
                    calm_rx = ~calm_rx;
                stall_left = calm_rx ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (out_stall && stall_left != 0)
                stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // ---- watchdog ----
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no beat moved for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int p;
        int unsigned k;
        slots = SIZE_RESET;
        reset_positions();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty ring, unlocked no-ops
        add_op(OP_READ, 0, 0, 0);
        add_op(OP_DELETE, 0, 0, 0);
        add_op(OP_UPDATE, 8'h77, 0, 0);
        add_op(OP_DISCARD, 0, 0, 0);
        add_op(OP_UNLOCK, 0, 0, 0);
        // field extremes, range checks
        add_op(OP_WRITE, 8'h00, 0, 0);
        add_op(OP_WRITE, 8'hFF, 0, 0);
        add_op(OP_WRITE, 8'hA5, 0, 0);
        add_op(OP_PEEK, 0, 8'hFF, 0);
        add_op(OP_UPDATE, 8'h5A, 8'd1, 0);
        add_op(OP_DELETE, 0, 0, 9'd0);
        add_op(OP_DELETE, 0, 0, 9'd511);
        // commit lock behaviour
        add_op(OP_LOCK, 0, 0, 0);
        add_op(OP_WRITE, 8'h11, 0, 0);
        add_op(OP_READ, 0, 0, 0);
        add_op(OP_PEEK, 0, 8'd2, 0);
        add_op(OP_UPDATE, 8'hC3, 8'd2, 0);
        add_op(OP_LOCK, 0, 0, 0);
        add_op(OP_WRITE, 8'h22, 0, 0);
        add_op(OP_DISCARD, 0, 0, 0);
        add_op(4'(OP_CODE_MAX), 8'hFF, 8'hFF, 9'h1FF);
        add_op(OP_CLEAR, 0, 0, 0);
        // locked at the head: nothing readable
        add_op(OP_LOCK, 0, 0, 0);
        add_op(OP_WRITE, 8'h33, 0, 0);
        add_op(OP_READ, 0, 0, 0);
        add_op(OP_UNLOCK, 0, 0, 0);

        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            repeat (SETTLE) @(posedge clk);
            set_ring_size(size_plan[p]);
            @(negedge clk);
            if (size_plan[p] == DEPTH_DEFAULT)
            begin
                for (k = 0; k < DEPTH_DEFAULT + 2; k++)
                    add_op(OP_WRITE, $urandom_range(0, 255), 0, 0);
                queue_phase(slots, op_backlog.size() + 40);
            end
            else
                queue_phase(slots, 70);
        end

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        $display("%0d ops over %0d ring sizes, %0d result beats checked, %0d mismatches",
                 ops_sent, sizes_tried, beats_checked, failures);
        $display("oldest-byte overwrites %0d, lock mark shifts %0d, rollbacks %0d",
                 overwrites, mark_shifts, rollbacks);
        if (failures == 0 && result_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
